FILE: src/assert_macros.svh
// assertion macros shared by the frame state machine and result register modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define DFR_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dfr assertion failed");

// next-cycle implication, sampled on clk, off while rst_n is low
`define DFR_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dfr assertion failed");

`endif

FILE: src/dfr_pkg.sv
// types and constants of the delimited frame receiver
package dfr_pkg;

    localparam logic [7:0] START_DELIM      = 8'h7E;
    localparam logic [7:0] SUM_GOOD         = 8'hFF;
    localparam logic [7:0] HUNT_LIMIT_RESET = 8'd30;

    // command codes
    localparam logic CMD_ATTENTION = 1'b0;
    localparam logic CMD_BYTE      = 1'b1;

    // result kinds
    typedef enum logic [1:0] {
        KIND_PAYLOAD  = 2'd0,
        KIND_GOOD     = 2'd1,
        KIND_BAD_SUM  = 2'd2,
        KIND_TIMEOUT  = 2'd3
    } dfr_kind_t;

    // one input word
    typedef struct packed {
        logic       command;
        logic [7:0] rx_byte;
    } dfr_item_t;

    // one result word
    typedef struct packed {
        dfr_kind_t  kind;
        logic [7:0] data;
        logic [7:0] index;
        logic [7:0] frame_length;
        logic       last;
    } dfr_result_t;

endpackage

FILE: src/delimited_frame_receiver_unit.sv
// top level of the delimited frame receiver
//
// Receives bytes of frames that open with the 0x7E delimiter: an attention word
// (command 0) starts a hunt while idle, then byte words (command 1) carry the
// length high and low bytes, the payload and the checksum. Each payload byte
// comes out with its index and the frame length; the frame ends with a good or
// bad checksum status word, and a hunt that sees hunt_limit misses ends with a
// timeout status on the next byte. The block takes one word per clock cycle
// unless a word with a result waits for room in the result register; a result
// passes the input register, one pass through the frame state machine and the
// result register before it reaches the outputs. A result waiting in the result
// register stalls the input only once the word behind it also has a result to
// give. hunt_limit is written through cfg_wr_en / cfg_wr_data and resets to 30.
module delimited_frame_receiver_unit
    import dfr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       command,
    input  logic [7:0] rx_byte,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [7:0] data,
    output logic [7:0] index,
    output logic [7:0] frame_length,
    output logic       last
);

    dfr_item_t   in_item;
    dfr_item_t   item;
    logic        item_valid;
    logic        consume;
    logic        out_space;
    logic        res_valid;
    dfr_result_t res;
    dfr_result_t out_res;

    assign in_item.command = command;
    assign in_item.rx_byte = rx_byte;

    // input register
    dfr_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .consume    (consume),
        .item_valid (item_valid),
        .item       (item)
    );

    // frame parser
    dfr_frame_fsm u_frame_fsm (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_valid  (item_valid),
        .item        (item),
        .out_space   (out_space),
        .consume     (consume),
        .res_valid   (res_valid),
        .res         (res)
    );

    // result register
    dfr_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (consume && res_valid),
        .res       (res),
        .out_space (out_space),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign kind         = out_res.kind;
    assign data         = out_res.data;
    assign index        = out_res.index;
    assign frame_length = out_res.frame_length;
    assign last         = out_res.last;

endmodule

FILE: src/dfr_in_stage.sv
// input register stage of the frame receiver
module dfr_in_stage
    import dfr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  dfr_item_t in_item,
    input  logic      consume,
    output logic      item_valid,
    output dfr_item_t item
);

    logic      valid_reg;
    logic      valid_next;
    dfr_item_t item_reg;

    // take a new word when empty or when the held word is consumed
    assign in_ready   = !valid_reg || consume;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (consume ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload holds until replaced
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

FILE: src/dfr_frame_fsm.sv
// frame state machine: hunt, length, payload and checksum handling
`include "assert_macros.svh"

module dfr_frame_fsm
    import dfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        item_valid,
    input  dfr_item_t   item,
    input  logic        out_space,
    output logic        consume,
    output logic        res_valid,
    output dfr_result_t res
);

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_HUNT    = 3'd1,
        PH_LEN_HI  = 3'd2,
        PH_LEN_LO  = 3'd3,
        PH_PAYLOAD = 3'd4,
        PH_CHECK   = 3'd5
    } phase_t;

    phase_t     phase_reg,          phase_next;
    logic [7:0] hunt_limit_reg;
    logic [7:0] miss_count_reg,     miss_count_next;
    logic [7:0] payload_length_reg, payload_length_next;
    logic [7:0] byte_position_reg,  byte_position_next;
    logic [7:0] running_sum_reg,    running_sum_next;
    logic [7:0] sum_plus;
    logic [7:0] pos_plus;

    assign sum_plus = running_sum_reg + item.rx_byte;
    assign pos_plus = byte_position_reg + 8'd1;

    // one step of the frame parser for the held word
    always_comb
    begin
        phase_next          = phase_reg;
        miss_count_next     = miss_count_reg;
        payload_length_next = payload_length_reg;
        byte_position_next  = byte_position_reg;
        running_sum_next    = running_sum_reg;
        res_valid           = 1'b0;
        res.kind            = KIND_PAYLOAD;
        res.data            = 8'd0;
        res.index           = 8'd0;
        res.frame_length    = 8'd0;
        res.last            = 1'b0;
        if (item.command == CMD_ATTENTION)
        begin
            // attention only starts a hunt from idle
            if (phase_reg == PH_IDLE)
            begin
                phase_next         = PH_HUNT;
                miss_count_next    = 8'd0;
                running_sum_next   = 8'd0;
                byte_position_next = 8'd0;
            end
        end
        else
        begin
            case (phase_reg)
                PH_IDLE:
                begin
                    phase_next = PH_IDLE;
                end
                PH_HUNT:
                begin
                    if (miss_count_reg >= hunt_limit_reg)
                    begin
                        phase_next = PH_IDLE;
                        res_valid  = item_valid;
                        res.kind   = KIND_TIMEOUT;
                        res.last   = 1'b1;
                    end
                    else if (item.rx_byte == START_DELIM)
                    begin
                        phase_next = PH_LEN_HI;
                    end
                    else
                    begin
                        miss_count_next = miss_count_reg + 8'd1;
                    end
                end
                PH_LEN_HI:
                begin
                    phase_next = PH_LEN_LO;
                end
                PH_LEN_LO:
                begin
                    payload_length_next = item.rx_byte;
                    byte_position_next  = 8'd0;
                    phase_next = (item.rx_byte == 8'd0) ? PH_CHECK : PH_PAYLOAD;
                end
                PH_PAYLOAD:
                begin
                    running_sum_next   = sum_plus;
                    byte_position_next = pos_plus;
                    if (pos_plus == payload_length_reg)
                    begin
                        phase_next = PH_CHECK;
                    end
                    res_valid        = item_valid;
                    res.kind         = KIND_PAYLOAD;
                    res.data         = item.rx_byte;
                    res.index        = byte_position_reg;
                    res.frame_length = payload_length_reg;
                end
                PH_CHECK:
                begin
                    running_sum_next = sum_plus;
                    phase_next       = PH_IDLE;
                    res_valid        = item_valid;
                    res.kind         = (sum_plus == SUM_GOOD) ? KIND_GOOD : KIND_BAD_SUM;
                    res.frame_length = payload_length_reg;
                    res.last         = 1'b1;
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // a word is consumed once its result, if any, has a place to go
    assign consume = item_valid && (!res_valid || out_space);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_IDLE;
            hunt_limit_reg     <= HUNT_LIMIT_RESET;
            miss_count_reg     <= 8'd0;
            payload_length_reg <= 8'd0;
            byte_position_reg  <= 8'd0;
            running_sum_reg    <= 8'd0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                hunt_limit_reg <= cfg_wr_data;
            end
            if (consume)
            begin
                phase_reg          <= phase_next;
                miss_count_reg     <= miss_count_next;
                payload_length_reg <= payload_length_next;
                byte_position_reg  <= byte_position_next;
                running_sum_reg    <= running_sum_next;
            end
        end
    end

    // checks
    `DFR_ASSERT_IMP(a_res_needs_item, res_valid, item_valid)
    `DFR_ASSERT_IMP(a_last_on_status, res_valid, res.last == (res.kind != KIND_PAYLOAD))
    `DFR_ASSERT_IMP(a_idle_byte_silent,
        item_valid && phase_reg == PH_IDLE, !res_valid)
    `DFR_ASSERT_NXT(a_check_returns_idle,
        consume && phase_reg == PH_CHECK && item.command == CMD_BYTE, phase_reg == PH_IDLE)

endmodule

FILE: src/dfr_out_stage.sv
// result register stage of the frame receiver
`include "assert_macros.svh"

module dfr_out_stage
    import dfr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  dfr_result_t res,
    output logic        out_space,
    output logic        out_valid,
    input  logic        out_ready,
    output dfr_result_t out_res
);

    logic        valid_reg;
    logic        valid_next;
    dfr_result_t res_reg;

    // room when empty or when the held word leaves this cycle
    assign out_space  = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

    // a load never overwrites a word that is still waiting
    `DFR_ASSERT_IMP(a_no_overwrite, load, !valid_reg || out_ready)

endmodule

FILE: tb/delimited_frame_receiver_unit_tb.sv
`timescale 1ns / 1ps
// testbench of the delimited frame receiver: directed and random frames checked against a predictor
module delimited_frame_receiver_unit_tb;
    import dfr_pkg::*;

    // receiver phases as the predictor tracks them
    typedef enum logic [2:0] {
        RX_IDLE,
        RX_HUNT,
        RX_LEN_HI,
        RX_LEN_LO,
        RX_PAYLOAD,
        RX_CHECK
    } rx_state_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = 8'd0;
    logic       in_valid = 1'b0;
    logic       in_ready;
    logic       command = CMD_ATTENTION;
    logic [7:0] rx_byte = 8'd0;
    logic       out_valid;
    logic       out_ready = 1'b0;
    logic [1:0] kind;
    logic [7:0] data;
    logic [7:0] index;
    logic [7:0] frame_length;
    logic       last;

    // words waiting to be sent and results still owed by the block
    dfr_item_t   frame_words[$];
    dfr_result_t expected_results[$];

    // predictor state
    logic [7:0] hunt_limit_now = HUNT_LIMIT_RESET;
    rx_state_t  rx_state = RX_IDLE;
    logic [7:0] misses = 8'd0;
    logic [7:0] pay_len = 8'd0;
    logic [7:0] pay_pos = 8'd0;
    logic [7:0] sum_acc = 8'd0;

    int unsigned error_count = 0;
    int unsigned cycle_count = 0;
    int unsigned words_queued = 0;
    int unsigned words_sent = 0;
    int unsigned payload_seen = 0;
    int unsigned good_seen = 0;
    int unsigned bad_seen = 0;
    int unsigned timeout_seen = 0;
    int unsigned mid_limit = 0;

    // stretch of cycles with no idling on either side
    wire calm = (cycle_count >= 400) && (cycle_count < 1000);

    delimited_frame_receiver_unit DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .command      (command),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .data         (data),
        .index        (index),
        .frame_length (frame_length),
        .last         (last)
    );

    // clock
    initial
    begin
        forever #6 clk = ~clk;
    end

    // one line per mismatch
    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    // advance the frame state by one word, return 1 when a result is owed
    function automatic bit receive_word(input dfr_item_t w, output dfr_result_t r);
        bit produced;
        produced = 1'b0;
        r = '0;
        if (w.command == CMD_ATTENTION)
        begin
            if (rx_state == RX_IDLE)
            begin
                rx_state = RX_HUNT;
                misses = 8'd0;
                sum_acc = 8'd0;
                pay_pos = 8'd0;
            end
        end
        else
        begin
            case (rx_state)
                RX_HUNT:
                begin
                    if (misses >= hunt_limit_now)
                    begin
                        rx_state = RX_IDLE;
                        r.kind = KIND_TIMEOUT;
                        r.last = 1'b1;
                        produced = 1'b1;
                    end
                    else if (w.rx_byte == START_DELIM)
                        rx_state = RX_LEN_HI;
                    else
                        misses = misses + 8'd1;
                end
                RX_LEN_HI:
                    rx_state = RX_LEN_LO;
                RX_LEN_LO:
                begin
                    pay_len = w.rx_byte;
                    pay_pos = 8'd0;
                    rx_state = (w.rx_byte == 8'd0) ? RX_CHECK : RX_PAYLOAD;
                end
                RX_PAYLOAD:
                begin
                    r.kind = KIND_PAYLOAD;
                    r.data = w.rx_byte;
                    r.index = pay_pos;
                    r.frame_length = pay_len;
                    sum_acc = sum_acc + w.rx_byte;
                    pay_pos = pay_pos + 8'd1;
                    if (pay_pos == pay_len)
                        rx_state = RX_CHECK;
                    produced = 1'b1;
                end
                RX_CHECK:
                begin
                    sum_acc = sum_acc + w.rx_byte;
                    rx_state = RX_IDLE;
                    r.kind = (sum_acc == SUM_GOOD) ? KIND_GOOD : KIND_BAD_SUM;
                    r.frame_length = pay_len;
                    r.last = 1'b1;
                    produced = 1'b1;
                end
                default:
                    ;
            endcase
        end
        return produced;
    endfunction

    // cycle counter for the calm stretch
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    // word driver
    always @(posedge clk)
    begin : drive_words
        dfr_result_t predicted;
        dfr_item_t   next_word;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                if (receive_word(dfr_item_t'{command, rx_byte}, predicted))
                    expected_results.push_back(predicted);
                words_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (frame_words.size() != 0 && (calm || $urandom_range(0, 99) >= 10))
                begin
                    next_word = frame_words.pop_front();
                    in_valid <= 1'b1;
                    command <= next_word.command;
                    rx_byte <= next_word.rx_byte;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin : check_results
        dfr_result_t want;
        if (rst_n)
        begin
            out_ready <= calm || ($urandom_range(0, 99) >= 10);
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                    report_mismatch("result with none pending, kind", kind, 0);
                else
                begin
                    want = expected_results.pop_front();
                    if (kind !== want.kind)
                        report_mismatch("kind", kind, want.kind);
                    if (data !== want.data)
                        report_mismatch("data", data, want.data);
                    if (index !== want.index)
                        report_mismatch("index", index, want.index);
                    if (frame_length !== want.frame_length)
                        report_mismatch("frame_length", frame_length, want.frame_length);
                    if (last !== want.last)
                        report_mismatch("last", last, want.last);
                    case (want.kind)
                        KIND_PAYLOAD: payload_seen++;
                        KIND_GOOD:    good_seen++;
                        KIND_BAD_SUM: bad_seen++;
                        default:      timeout_seen++;
                    endcase
                end
            end
        end
    end

    // queue one word
    task automatic push_word(logic cmd, logic [7:0] b);
        frame_words.push_back(dfr_item_t'{cmd, b});
        words_queued++;
    endtask

    // any byte but the delimiter
    function automatic logic [7:0] miss_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == START_DELIM)
            b = b + 8'd1;
        return b;
    endfunction

    // attention, hunt misses, delimiter, length, payload, checksum; cut trims the tail
    task automatic push_frame(int n_miss, int len, bit good_sum, int cut);
        dfr_item_t  seq[$];
        logic [7:0] b;
        logic [7:0] sum;
        sum = 8'd0;
        seq.push_back(dfr_item_t'{CMD_ATTENTION, 8'($urandom_range(0, 255))});
        for (int i = 0; i < n_miss; i++)
            seq.push_back(dfr_item_t'{CMD_BYTE, miss_byte()});
        seq.push_back(dfr_item_t'{CMD_BYTE, START_DELIM});
        seq.push_back(dfr_item_t'{CMD_BYTE, 8'($urandom_range(0, 255))});
        seq.push_back(dfr_item_t'{CMD_BYTE, 8'(len)});
        for (int i = 0; i < len; i++)
        begin
            b = 8'($urandom_range(0, 255));
            sum = sum + b;
            seq.push_back(dfr_item_t'{CMD_BYTE, b});
        end
        b = good_sum ? SUM_GOOD - sum : 8'($urandom_range(0, 255));
        seq.push_back(dfr_item_t'{CMD_BYTE, b});
        for (int i = 0; i < seq.size() && i < cut; i++)
            push_word(seq[i].command, seq[i].rx_byte);
    endtask

    // hunt that runs out of misses, ended by final_byte
    task automatic push_timeout(int limit, logic [7:0] final_byte);
        push_word(CMD_ATTENTION, 8'd0);
        for (int i = 0; i < limit; i++)
            push_word(CMD_BYTE, miss_byte());
        push_word(CMD_BYTE, final_byte);
    endtask

    // mostly short frames, a few at full length
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 90)
            return $urandom_range(0, 12);
        else if (r < 93)
            return 255;
        return $urandom_range(13, 254);
    endfunction

    // misses before the delimiter, sometimes one short of the limit
    function automatic int pick_misses();
        int top;
        if (hunt_limit_now == 8'd0)
            return 0;
        if (hunt_limit_now <= 8'd40 && $urandom_range(0, 99) < 20)
            return hunt_limit_now - 1;
        top = (hunt_limit_now - 1 < 3) ? hunt_limit_now - 1 : 3;
        return $urandom_range(0, top);
    endfunction

    // random mix of frames, timeouts, cut frames and noise
    task automatic random_traffic(int n_words);
        int stop_at;
        int pick;
        int n_miss;
        int len;
        stop_at = words_queued + n_words;
        while (words_queued < stop_at)
        begin
            pick = $urandom_range(0, 99);
            n_miss = pick_misses();
            len = pick_len();
            if (pick < 62)
                push_frame(n_miss, len, $urandom_range(0, 99) < 70, 1 << 20);
            else if (pick < 74 && hunt_limit_now <= 8'd40)
                push_timeout(hunt_limit_now, 8'($urandom_range(0, 255)));
            else if (pick < 86)
                push_frame(n_miss, len, 1'b1, $urandom_range(1, n_miss + len + 4));
            else
            begin
                repeat ($urandom_range(1, 4))
                    push_word(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)));
            end
        end
    endtask

    // wait until every word is sent and every result is back, then let the pipe empty
    task automatic settle_block();
        int guard;
        guard = 0;
        while ((frame_words.size() != 0 || in_valid || expected_results.size() != 0)
               && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        if (frame_words.size() != 0)
        begin
            report_mismatch("words never accepted", frame_words.size(), 0);
            frame_words.delete();
        end
        if (expected_results.size() != 0)
        begin
            report_mismatch("results never arrived", 0, expected_results.size());
            expected_results.delete();
        end
        repeat (6) @(posedge clk);
    endtask

    // write the hunt limit while the block is quiet
    task automatic write_hunt_limit(logic [7:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        hunt_limit_now = value;
    endtask

    // stimulus and final verdict
    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // byte while idle, attention while busy, good frame, zero length, bad checksum
        push_word(CMD_BYTE, 8'h00);
        push_word(CMD_ATTENTION, 8'h00);
        push_word(CMD_ATTENTION, 8'hFF);
        push_word(CMD_BYTE, 8'hFF);
        push_word(CMD_BYTE, START_DELIM);
        push_word(CMD_BYTE, 8'hFF);
        push_word(CMD_BYTE, 8'h02);
        push_word(CMD_BYTE, 8'h00);
        push_word(CMD_BYTE, 8'hFF);
        push_word(CMD_BYTE, 8'h00);
        push_word(CMD_ATTENTION, 8'h00);
        push_word(CMD_BYTE, START_DELIM);
        push_word(CMD_BYTE, 8'h00);
        push_word(CMD_BYTE, 8'h00);
        push_word(CMD_BYTE, SUM_GOOD);
        push_word(CMD_ATTENTION, 8'h00);
        push_word(CMD_BYTE, START_DELIM);
        push_word(CMD_BYTE, 8'h00);
        push_word(CMD_BYTE, 8'h01);
        push_word(CMD_BYTE, 8'h80);
        push_word(CMD_BYTE, 8'h00);
        settle_block();

        // zero limit: first hunt byte times out, delimiter included
        write_hunt_limit(8'd0);
        push_word(CMD_ATTENTION, 8'h00);
        push_word(CMD_BYTE, START_DELIM);
        push_word(CMD_ATTENTION, 8'h00);
        push_word(CMD_BYTE, 8'h00);
        random_traffic(60);
        settle_block();

        // largest limit: a full-length hunt ended by a delimiter, then a longest frame
        write_hunt_limit(8'd255);
        push_timeout(255, START_DELIM);
        push_frame(0, 255, 1'b1, 1 << 20);
        random_traffic(80);
        settle_block();

        write_hunt_limit(8'd1);
        random_traffic(150);
        settle_block();

        mid_limit = $urandom_range(2, 40);
        write_hunt_limit(8'(mid_limit));
        random_traffic(150);
        settle_block();

        write_hunt_limit(HUNT_LIMIT_RESET);
        random_traffic(150);
        settle_block();

        $display("sent %0d words: %0d payload bytes, %0d good frames, %0d bad checksums, %0d timeouts",
                 words_sent, payload_seen, good_seen, bad_seen, timeout_seen);
        $display("hunt limits covered: 30, 0, 255, 1, %0d, 30", mid_limit);
        if (error_count == 0)
            $display("delimited_frame_receiver_unit_tb: PASS");
        else
            $display("delimited_frame_receiver_unit_tb: FAIL");
        $finish;
    end

    // run limit
    initial
    begin
        #5_000_000;
        $display("delimited_frame_receiver_unit_tb: FAIL");
        $finish;
    end

endmodule
